// File: src/bld_pkg.sv
// ----------------------------------------------------------------------------
// bld_pkg
// Shared types, constants and functions for the binary log deframer.
// ----------------------------------------------------------------------------
package bld_pkg;

    localparam logic [7:0] SYNC0 = 8'hAA;
    localparam logic [7:0] SYNC1 = 8'h44;
    localparam logic [7:0] SYNC2 = 8'h12;

    localparam int HEADER_BYTES = 28;
    localparam int HDR_POS_W    = 5;

    localparam logic [15:0] ID_OBS     = 16'd43;
    localparam logic [15:0] ID_GPS_EPH = 16'd7;
    localparam logic [15:0] ID_BDS_EPH = 16'd1696;

    localparam int CFG_ADDR_W = 3;

    localparam logic [31:0] CRC_POLY_RESET = 32'hEDB8_8320;
    localparam logic [15:0] MAX_LEN_RESET  = 16'd4096;

    typedef enum logic [0:0] {
        REG_CRC_POLY = 1'b0,
        REG_MAX_LEN  = 1'b1
    } reg_index_t;

    typedef enum logic [0:0] {
        KIND_BODY   = 1'b0,
        KIND_STATUS = 1'b1
    } result_kind_t;

    typedef enum logic [1:0] {
        STATUS_GOOD     = 2'd0,
        STATUS_CRC_BAD  = 2'd1,
        STATUS_TOO_LONG = 2'd2
    } frame_status_t;

    typedef enum logic [1:0] {
        CLASS_OBS     = 2'd0,
        CLASS_GPS_EPH = 2'd1,
        CLASS_BDS_EPH = 2'd2,
        CLASS_OTHER   = 2'd3
    } message_class_t;

    typedef enum logic [5:0] {
        PH_HUNT0  = 6'b000001,
        PH_HUNT1  = 6'b000010,
        PH_HUNT2  = 6'b000100,
        PH_HEADER = 6'b001000,
        PH_BODY   = 6'b010000,
        PH_CRC    = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [31:0] crc_polynomial;
        logic [15:0] max_body_length;
    } cfg_t;

    typedef struct packed {
        result_kind_t   result_kind;
        logic [7:0]     body_byte;
        logic [15:0]    body_index;
        logic [15:0]    message_id;
        message_class_t message_class;
        logic [15:0]    body_length;
        logic [15:0]    gps_week;
        logic [31:0]    week_milliseconds;
        frame_status_t  frame_status;
    } result_t;

    // Reflected CRC-32, one byte, eight shift steps
    function automatic logic [31:0] crc_byte(
        input logic [31:0] crc,
        input logic [7:0]  data,
        input logic [31:0] poly
    );
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ poly;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic message_class_t class_of(input logic [15:0] id);
        message_class_t cls;
        if (id == ID_OBS)
            cls = CLASS_OBS;
        else if (id == ID_GPS_EPH)
            cls = CLASS_GPS_EPH;
        else if (id == ID_BDS_EPH)
            cls = CLASS_BDS_EPH;
        else
            cls = CLASS_OTHER;
        return cls;
    endfunction

endpackage

// File: src/bld_if.sv
// ----------------------------------------------------------------------------
// bld_if
// Valid/ready channels of the deframer: byte stream in, results out.
// ----------------------------------------------------------------------------
interface bld_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface bld_result_if import bld_pkg::*; ;
    logic           valid;
    logic           ready;
    result_kind_t   result_kind;
    logic [7:0]     body_byte;
    logic [15:0]    body_index;
    logic [15:0]    message_id;
    message_class_t message_class;
    logic [15:0]    body_length;
    logic [15:0]    gps_week;
    logic [31:0]    week_milliseconds;
    frame_status_t  frame_status;

    modport source (
        output valid, output result_kind, output body_byte, output body_index,
        output message_id, output message_class, output body_length,
        output gps_week, output week_milliseconds, output frame_status,
        input ready
    );
    modport sink (
        input valid, input result_kind, input body_byte, input body_index,
        input message_id, input message_class, input body_length,
        input gps_week, input week_milliseconds, input frame_status,
        output ready
    );
endinterface

// File: src/bld_apb_regs.sv
// ----------------------------------------------------------------------------
// bld_apb_regs
// APB configuration registers: CRC polynomial and body length limit.
// ----------------------------------------------------------------------------
module bld_apb_regs import bld_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    reg_index_t index;
    logic       wr_en;

    assign pready = 1'b1;
    assign index  = reg_index_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crc_polynomial  <= CRC_POLY_RESET;
            cfg_reg.max_body_length <= MAX_LEN_RESET;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_CRC_POLY: cfg_reg.crc_polynomial  <= pwdata;
                REG_MAX_LEN:  cfg_reg.max_body_length <= pwdata[15:0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_CRC_POLY: prdata = cfg_reg.crc_polynomial;
            REG_MAX_LEN:  prdata = {16'd0, cfg_reg.max_body_length};
            default:      prdata = '0;
        endcase
    end

endmodule

// File: src/binary_log_deframer_crc32.sv
// ----------------------------------------------------------------------------
// binary_log_deframer_crc32
// Sync-word deframer for a binary log byte stream with CRC-32 frame check.
//
//   channel      dir  handshake      word
//   byte_in      in   valid/ready    data_byte
//   result_out   out  valid/ready    body byte with index, or frame status
//   apb          in   psel/penable   crc_polynomial, max_body_length
//
// One byte a cycle, sustained while the result side is ready.
// Input register, then one pass (phase decode, 8-step CRC update, header
// capture) into the result register.
// Reset hunts for the first sync byte; no clearing pass.
// A stalled result holds the pass; the input register still takes one byte.
// ----------------------------------------------------------------------------
module binary_log_deframer_crc32 import bld_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    bld_byte_if.sink              byte_in,
    bld_result_if.source          result_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t cfg;

    bld_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // frame state
    phase_t               phase_reg,   phase_next;
    logic [HDR_POS_W-1:0] hdr_pos_reg, hdr_pos_next;
    logic [15:0]          body_idx_reg, body_idx_next;
    logic [1:0]           crc_cnt_reg, crc_cnt_next;
    logic [31:0]          crc_reg,     crc_next;
    logic [23:0]          rx_crc_reg,  rx_crc_next;
    logic [15:0]          id_reg,      id_next;
    logic [15:0]          len_reg,     len_next;
    logic [15:0]          week_reg,    week_next;
    logic [31:0]          ms_reg,      ms_next;

    // result register
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg,   out_res_next;

    logic        advance;
    logic        step;
    logic [7:0]  b;
    logic [31:0] crc_upd;
    logic [31:0] crc_start;

    assign advance       = !out_valid_reg || result_out.ready;
    assign step          = in_valid_reg && advance;
    assign byte_in.ready = !in_valid_reg || advance;
    assign b             = in_byte_reg;
    assign crc_upd       = crc_byte(crc_reg, b, cfg.crc_polynomial);
    assign crc_start     = crc_byte(32'd0, b, cfg.crc_polynomial);

    always_comb
    begin
        phase_next     = phase_reg;
        hdr_pos_next   = hdr_pos_reg;
        body_idx_next  = body_idx_reg;
        crc_cnt_next   = crc_cnt_reg;
        crc_next       = crc_reg;
        rx_crc_next    = rx_crc_reg;
        id_next        = id_reg;
        len_next       = len_reg;
        week_next      = week_reg;
        ms_next        = ms_reg;
        out_valid_next = out_valid_reg && !result_out.ready;
        out_res_next   = out_res_reg;

        if (step)
        begin
            out_valid_next = 1'b0;
            unique case (phase_reg)
                PH_HUNT0:
                begin
                    if (b == SYNC0)
                    begin
                        phase_next = PH_HUNT1;
                        crc_next   = crc_start;
                    end
                end
                PH_HUNT1:
                begin
                    if (b == SYNC1)
                    begin
                        phase_next = PH_HUNT2;
                        crc_next   = crc_upd;
                    end
                    else if (b == SYNC0)
                    begin
                        crc_next   = crc_start;
                    end
                    else
                    begin
                        phase_next = PH_HUNT0;
                    end
                end
                PH_HUNT2:
                begin
                    if (b == SYNC2)
                    begin
                        phase_next   = PH_HEADER;
                        crc_next     = crc_upd;
                        hdr_pos_next = HDR_POS_W'(3);
                    end
                    else if (b == SYNC0)
                    begin
                        phase_next = PH_HUNT1;
                        crc_next   = crc_start;
                    end
                    else
                    begin
                        phase_next = PH_HUNT0;
                    end
                end
                PH_HEADER:
                begin
                    crc_next     = crc_upd;
                    hdr_pos_next = hdr_pos_reg + HDR_POS_W'(1);
                    case (hdr_pos_reg)
                        HDR_POS_W'(4):  id_next[7:0]    = b;
                        HDR_POS_W'(5):  id_next[15:8]   = b;
                        HDR_POS_W'(8):  len_next[7:0]   = b;
                        HDR_POS_W'(9):  len_next[15:8]  = b;
                        HDR_POS_W'(14): week_next[7:0]  = b;
                        HDR_POS_W'(15): week_next[15:8] = b;
                        HDR_POS_W'(16): ms_next[7:0]    = b;
                        HDR_POS_W'(17): ms_next[15:8]   = b;
                        HDR_POS_W'(18): ms_next[23:16]  = b;
                        HDR_POS_W'(19): ms_next[31:24]  = b;
                        default: ;
                    endcase
                    if (hdr_pos_reg == HDR_POS_W'(HEADER_BYTES - 1))
                    begin
                        body_idx_next = '0;
                        crc_cnt_next  = '0;
                        if (len_reg > cfg.max_body_length)
                        begin
                            phase_next                     = PH_HUNT0;
                            out_valid_next                 = 1'b1;
                            out_res_next.result_kind       = KIND_STATUS;
                            out_res_next.body_byte         = '0;
                            out_res_next.body_index        = '0;
                            out_res_next.message_id        = id_reg;
                            out_res_next.message_class     = class_of(id_reg);
                            out_res_next.body_length       = len_reg;
                            out_res_next.gps_week          = week_reg;
                            out_res_next.week_milliseconds = ms_reg;
                            out_res_next.frame_status      = STATUS_TOO_LONG;
                        end
                        else if (len_reg == 16'd0)
                        begin
                            phase_next = PH_CRC;
                        end
                        else
                        begin
                            phase_next = PH_BODY;
                        end
                    end
                end
                PH_BODY:
                begin
                    crc_next                       = crc_upd;
                    body_idx_next                  = body_idx_reg + 16'd1;
                    out_valid_next                 = 1'b1;
                    out_res_next.result_kind       = KIND_BODY;
                    out_res_next.body_byte         = b;
                    out_res_next.body_index        = body_idx_reg;
                    out_res_next.message_id        = id_reg;
                    out_res_next.message_class     = class_of(id_reg);
                    out_res_next.body_length       = len_reg;
                    out_res_next.gps_week          = week_reg;
                    out_res_next.week_milliseconds = ms_reg;
                    out_res_next.frame_status      = STATUS_GOOD;
                    if (({1'b0, body_idx_reg} + 17'd1) >= {1'b0, len_reg})
                    begin
                        phase_next   = PH_CRC;
                        crc_cnt_next = '0;
                    end
                end
                PH_CRC:
                begin
                    crc_cnt_next = crc_cnt_reg + 2'd1;
                    case (crc_cnt_reg)
                        2'd0:    rx_crc_next[7:0]   = b;
                        2'd1:    rx_crc_next[15:8]  = b;
                        2'd2:    rx_crc_next[23:16] = b;
                        default: ;
                    endcase
                    if (crc_cnt_reg == 2'd3)
                    begin
                        phase_next                     = PH_HUNT0;
                        out_valid_next                 = 1'b1;
                        out_res_next.result_kind       = KIND_STATUS;
                        out_res_next.body_byte         = '0;
                        out_res_next.body_index        = '0;
                        out_res_next.message_id        = id_reg;
                        out_res_next.message_class     = class_of(id_reg);
                        out_res_next.body_length       = len_reg;
                        out_res_next.gps_week          = week_reg;
                        out_res_next.week_milliseconds = ms_reg;
                        out_res_next.frame_status      =
                            ({b, rx_crc_reg} == crc_reg) ? STATUS_GOOD : STATUS_CRC_BAD;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HUNT0;
            hdr_pos_reg   <= '0;
            body_idx_reg  <= '0;
            crc_cnt_reg   <= '0;
        end
        else
        begin
            if (byte_in.ready)
                in_valid_reg <= byte_in.valid;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            hdr_pos_reg   <= hdr_pos_next;
            body_idx_reg  <= body_idx_next;
            crc_cnt_reg   <= crc_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.ready && byte_in.valid)
            in_byte_reg <= byte_in.data_byte;
        crc_reg     <= crc_next;
        rx_crc_reg  <= rx_crc_next;
        id_reg      <= id_next;
        len_reg     <= len_next;
        week_reg    <= week_next;
        ms_reg      <= ms_next;
        out_res_reg <= out_res_next;
    end

    assign result_out.valid             = out_valid_reg;
    assign result_out.result_kind       = out_res_reg.result_kind;
    assign result_out.body_byte         = out_res_reg.body_byte;
    assign result_out.body_index        = out_res_reg.body_index;
    assign result_out.message_id        = out_res_reg.message_id;
    assign result_out.message_class     = out_res_reg.message_class;
    assign result_out.body_length       = out_res_reg.body_length;
    assign result_out.gps_week          = out_res_reg.gps_week;
    assign result_out.week_milliseconds = out_res_reg.week_milliseconds;
    assign result_out.frame_status      = out_res_reg.frame_status;

endmodule

// File: src/bld_checker.sv
// ----------------------------------------------------------------------------
// bld_checker
// Port-level checks on the deframer result stream, bound to the top level.
// ----------------------------------------------------------------------------
module bld_checker import bld_pkg::*;
(
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input result_kind_t   result_kind,
    input logic [7:0]     body_byte,
    input logic [15:0]    body_index,
    input frame_status_t  frame_status
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind)
            && $stable(body_byte) && $stable(body_index) && $stable(frame_status))
        else $error("stalled result word changed");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_STATUS |->
            body_byte == 8'd0 && body_index == 16'd0
            && (frame_status == STATUS_GOOD || frame_status == STATUS_CRC_BAD
                || frame_status == STATUS_TOO_LONG))
        else $error("malformed status word");

    a_body_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_BODY |-> frame_status == STATUS_GOOD)
        else $error("body word carries a final status");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result word without an accepted byte");

endmodule

bind binary_log_deframer_crc32 bld_checker u_bld_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (byte_in.valid),
    .in_ready     (byte_in.ready),
    .out_valid    (result_out.valid),
    .out_ready    (result_out.ready),
    .result_kind  (result_out.result_kind),
    .body_byte    (result_out.body_byte),
    .body_index   (result_out.body_index),
    .frame_status (result_out.frame_status)
);

// File: tb/sv/binary_log_deframer_crc32_test.sv
// ----------------------------------------------------------------------------
// binary_log_deframer_crc32_test
// Self-checking bench for the sync-word deframer. Frames with sync lead-ins,
// headers, bodies and good or corrupted CRC-32 trailers are streamed in
// under random gaps and back-pressure. A local deframer tracks sync, header,
// body and CRC per accepted byte, and every result word is compared with
// the oldest pending word. Register settings are changed between phases.
// ----------------------------------------------------------------------------
module binary_log_deframer_crc32_test;
    import bld_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DIRECTED_ROWS   = 10;

    typedef enum logic [2:0] {
        LEAD_CLEAN,
        LEAD_NOISE,
        LEAD_DOUBLE_AA,
        LEAD_RESYNC,
        LEAD_BAD_THIRD,
        LEAD_BAD_SECOND
    } lead_t;

    typedef struct packed {
        lead_t         lead;
        logic [15:0]   id;
        logic [15:0]   len;
        logic [15:0]   week;
        logic [31:0]   ms;
        logic          bad_crc;
        logic          typed;
        frame_status_t status;
    } frame_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    bld_byte_if   byte_ch ();
    bld_result_if result_ch ();

    binary_log_deframer_crc32 u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_ch),
        .result_out (result_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #1 clk = ~clk;

    cfg_t        live_cfg    = '{CRC_POLY_RESET, MAX_LEN_RESET};
    phase_t      track_phase = PH_HUNT0;
    logic [16:0] track_pos   = '0;
    logic [31:0] run_crc     = '0;
    logic [31:0] rx_crc      = '0;
    logic [15:0] held_id     = '0;
    logic [15:0] held_len    = '0;
    logic [15:0] held_week   = '0;
    logic [31:0] held_ms     = '0;

    result_t pending_words[$];
    logic    mismatch_seen = 1'b0;
    logic    hold_off_req  = 1'b0;
    int      bytes_sent    = 0;
    int      cycles        = 0;
    int      tx_run_left   = 0;
    logic    tx_gappy      = 1'b0;

    frame_row_t directed_rows [DIRECTED_ROWS] = '{
        '{LEAD_CLEAN,      ID_OBS,     16'd0,    16'd0,    32'd0,
          1'b0, 1'b1, STATUS_GOOD},
        '{LEAD_NOISE,      ID_GPS_EPH, 16'd3,    16'hFFFF, 32'hFFFF_FFFF,
          1'b0, 1'b1, STATUS_GOOD},
        '{LEAD_DOUBLE_AA,  ID_BDS_EPH, 16'd1,    16'h0001, 32'h0000_0001,
          1'b0, 1'b0, STATUS_GOOD},
        '{LEAD_RESYNC,     16'hFFFF,   16'd2,    16'h8000, 32'h8000_0000,
          1'b1, 1'b1, STATUS_CRC_BAD},
        '{LEAD_BAD_THIRD,  16'h0000,   16'd0,    16'h1234, 32'h1234_5678,
          1'b1, 1'b1, STATUS_CRC_BAD},
        '{LEAD_BAD_SECOND, 16'd1234,   16'd4097, 16'h00FF, 32'h00FF_00FF,
          1'b0, 1'b1, STATUS_TOO_LONG},
        '{LEAD_CLEAN,      ID_OBS,     16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
          1'b0, 1'b1, STATUS_TOO_LONG},
        '{LEAD_CLEAN,      16'd44,     16'd5,    16'd2210, 32'd345_600_000,
          1'b0, 1'b0, STATUS_GOOD},
        '{LEAD_CLEAN,      16'd1695,   16'd8,    16'h7FFF, 32'h7FFF_FFFF,
          1'b0, 1'b0, STATUS_GOOD},
        '{LEAD_CLEAN,      16'd8,      16'd12,   16'h5A5A, 32'hA5A5_5A5A,
          1'b0, 1'b0, STATUS_GOOD}
    };

    function automatic logic [31:0] crc_advance(
        input logic [31:0] acc,
        input logic [7:0]  b,
        input logic [31:0] poly
    );
        logic [31:0] r;
        r = acc ^ {24'd0, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
        return r;
    endfunction

    function automatic message_class_t frame_class(input logic [15:0] id);
        message_class_t c;
        case (id)
            ID_OBS:     c = CLASS_OBS;
            ID_GPS_EPH: c = CLASS_GPS_EPH;
            ID_BDS_EPH: c = CLASS_BDS_EPH;
            default:    c = CLASS_OTHER;
        endcase
        return c;
    endfunction

    function automatic result_t make_word(
        input result_kind_t  kind,
        input logic [7:0]    b,
        input logic [15:0]   idx,
        input frame_status_t status
    );
        result_t w;
        w.result_kind       = kind;
        w.body_byte         = b;
        w.body_index        = idx;
        w.message_id        = held_id;
        w.message_class     = frame_class(held_id);
        w.body_length       = held_len;
        w.gps_week          = held_week;
        w.week_milliseconds = held_ms;
        w.frame_status      = status;
        return w;
    endfunction

    task automatic open_frame(input logic [7:0] b);
        track_phase = PH_HUNT1;
        track_pos   = 17'd1;
        run_crc     = crc_advance(32'd0, b, live_cfg.crc_polynomial);
    endtask

    task automatic deframe_byte(
        input logic [7:0]    b,
        input logic          pin,
        input frame_status_t pin_status
    );
        logic [31:0]   rel;
        frame_status_t st;
        case (track_phase)
            PH_HUNT1:
            begin
                if (b == SYNC1)
                begin
                    track_phase = PH_HUNT2;
                    track_pos   = 17'd2;
                    run_crc     = crc_advance(run_crc, b, live_cfg.crc_polynomial);
                end
                else if (b == SYNC0)
                    open_frame(b);
                else
                    track_phase = PH_HUNT0;
            end
            PH_HUNT2:
            begin
                if (b == SYNC2)
                begin
                    track_phase = PH_HEADER;
                    track_pos   = 17'd3;
                    run_crc     = crc_advance(run_crc, b, live_cfg.crc_polynomial);
                end
                else if (b == SYNC0)
                    open_frame(b);
                else
                    track_phase = PH_HUNT0;
            end
            PH_HEADER:
            begin
                run_crc = crc_advance(run_crc, b, live_cfg.crc_polynomial);
                case (track_pos)
                    4:  held_id[7:0]    = b;
                    5:  held_id[15:8]   = b;
                    8:  held_len[7:0]   = b;
                    9:  held_len[15:8]  = b;
                    14: held_week[7:0]  = b;
                    15: held_week[15:8] = b;
                    16: held_ms[7:0]    = b;
                    17: held_ms[15:8]   = b;
                    18: held_ms[23:16]  = b;
                    19: held_ms[31:24]  = b;
                    default: ;
                endcase
                track_pos = track_pos + 17'd1;
                if (track_pos == HEADER_BYTES)
                begin
                    if (held_len > live_cfg.max_body_length)
                    begin
                        st = pin ? pin_status : STATUS_TOO_LONG;
                        pending_words.push_back(make_word(KIND_STATUS, 8'd0, 16'd0, st));
                        track_phase = PH_HUNT0;
                        track_pos   = '0;
                    end
                    else
                    begin
                        rx_crc      = '0;
                        track_phase = (held_len == 16'd0) ? PH_CRC : PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                rel     = {15'd0, track_pos} - HEADER_BYTES;
                run_crc = crc_advance(run_crc, b, live_cfg.crc_polynomial);
                pending_words.push_back(make_word(KIND_BODY, b, rel[15:0], STATUS_GOOD));
                track_pos = track_pos + 17'd1;
                if (rel + 32'd1 >= {16'd0, held_len})
                    track_phase = PH_CRC;
            end
            PH_CRC:
            begin
                rel = {15'd0, track_pos} - HEADER_BYTES - {16'd0, held_len};
                case (rel[1:0])
                    2'd0: rx_crc[7:0]   = b;
                    2'd1: rx_crc[15:8]  = b;
                    2'd2: rx_crc[23:16] = b;
                    2'd3: rx_crc[31:24] = b;
                endcase
                track_pos = track_pos + 17'd1;
                if (rel[1:0] == 2'd3)
                begin
                    st = (rx_crc == run_crc) ? STATUS_GOOD : STATUS_CRC_BAD;
                    if (pin)
                        st = pin_status;
                    pending_words.push_back(make_word(KIND_STATUS, 8'd0, 16'd0, st));
                    track_phase = PH_HUNT0;
                    track_pos   = '0;
                end
            end
            default:
            begin
                if (b == SYNC0)
                    open_frame(b);
                else
                    track_phase = PH_HUNT0;
            end
        endcase
    endtask

    task automatic push_byte(
        input logic [7:0]    b,
        input logic          pin,
        input frame_status_t pin_status
    );
        int gap;
        gap = 0;
        if (tx_run_left == 0)
        begin
            tx_gappy    = ($urandom_range(0, 2) != 0);
            tx_run_left = $urandom_range(16, 96);
        end
        tx_run_left--;
        if (tx_gappy && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
        deframe_byte(b, pin, pin_status);
        bytes_sent++;
    endtask

    task automatic send_frame(input frame_row_t row);
        logic [7:0]  fb[$];
        logic [31:0] crc;
        logic [7:0]  x;
        int          k;
        case (row.lead)
            LEAD_NOISE:
            begin
                repeat ($urandom_range(1, 4))
                begin
                    x = 8'($urandom_range(0, 255));
                    if (x == SYNC0)
                        x = 8'h00;
                    fb.push_back(x);
                end
            end
            LEAD_DOUBLE_AA:
                fb.push_back(SYNC0);
            LEAD_RESYNC:
            begin
                fb.push_back(SYNC0);
                fb.push_back(SYNC1);
            end
            LEAD_BAD_THIRD:
            begin
                fb.push_back(SYNC0);
                fb.push_back(SYNC1);
                fb.push_back(SYNC2 ^ 8'h01);
            end
            LEAD_BAD_SECOND:
            begin
                fb.push_back(SYNC0);
                fb.push_back(SYNC1 ^ 8'h01);
            end
            default: ;
        endcase
        crc = '0;
        for (k = 0; k < HEADER_BYTES; k++)
        begin
            case (k)
                0:  x = SYNC0;
                1:  x = SYNC1;
                2:  x = SYNC2;
                4:  x = row.id[7:0];
                5:  x = row.id[15:8];
                8:  x = row.len[7:0];
                9:  x = row.len[15:8];
                14: x = row.week[7:0];
                15: x = row.week[15:8];
                16: x = row.ms[7:0];
                17: x = row.ms[15:8];
                18: x = row.ms[23:16];
                19: x = row.ms[31:24];
                default: x = 8'($urandom_range(0, 255));
            endcase
            crc = crc_advance(crc, x, live_cfg.crc_polynomial);
            fb.push_back(x);
        end
        if (row.len <= live_cfg.max_body_length)
        begin
            for (k = 0; k < row.len; k++)
            begin
                x   = 8'($urandom_range(0, 255));
                crc = crc_advance(crc, x, live_cfg.crc_polynomial);
                fb.push_back(x);
            end
            if (row.bad_crc)
                crc = crc ^ (32'd1 << $urandom_range(0, 31));
            fb.push_back(crc[7:0]);
            fb.push_back(crc[15:8]);
            fb.push_back(crc[23:16]);
            fb.push_back(crc[31:24]);
        end
        for (k = 0; k < fb.size(); k++)
            push_byte(fb[k], row.typed && (k == fb.size() - 1), row.status);
    endtask

    task automatic random_traffic(input int budget);
        int          stop_at;
        int          pick;
        int          maxl;
        frame_row_t  row;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(0, 19);
            maxl = live_cfg.max_body_length;
            if (pick == 0)
            begin
                repeat ($urandom_range(1, 6))
                    push_byte(8'($urandom_range(0, 255)), 1'b0, STATUS_GOOD);
            end
            else if (pick == 1)
            begin
                push_byte(SYNC0, 1'b0, STATUS_GOOD);
                push_byte(8'($urandom_range(0, 1) ? SYNC1 : $urandom_range(0, 255)),
                          1'b0, STATUS_GOOD);
                push_byte(8'($urandom_range(0, 255)), 1'b0, STATUS_GOOD);
            end
            else
            begin
                row.lead = ($urandom_range(0, 3) == 0) ? lead_t'($urandom_range(0, 5))
                                                       : LEAD_CLEAN;
                case ($urandom_range(0, 4))
                    0:       row.id = ID_OBS;
                    1:       row.id = ID_GPS_EPH;
                    2:       row.id = ID_BDS_EPH;
                    default: row.id = 16'($urandom_range(0, 65535));
                endcase
                pick = $urandom_range(0, 19);
                if (pick < 13)
                    row.len = 16'($urandom_range(0, (maxl < 10) ? maxl : 10));
                else if (pick < 15)
                    row.len = 16'((maxl > 40) ? $urandom_range(20, 40) : maxl);
                else if (pick < 17)
                    row.len = 16'((maxl <= 64) ? maxl : $urandom_range(0, 10));
                else if (maxl < 65535)
                    row.len = 16'($urandom_range(maxl + 1, 65535));
                else
                    row.len = 16'($urandom_range(0, 10));
                row.week    = 16'($urandom_range(0, 65535));
                row.ms      = $urandom;
                row.bad_crc = ($urandom_range(0, 6) == 0);
                row.typed   = 1'b0;
                row.status  = STATUS_GOOD;
                send_frame(row);
            end
        end
    endtask

    task automatic drain();
        byte_ch.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t r, input logic [31:0] v);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (r == REG_CRC_POLY)
            live_cfg.crc_polynomial = v;
        else
            live_cfg.max_body_length = v[15:0];
        @(posedge clk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        got      = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (r == REG_CRC_POLY && got !== v)
        begin
            $error("crc_polynomial: expected %h, got %h", v, got);
            mismatch_seen = 1'b1;
        end
        if (r == REG_MAX_LEN && got[15:0] !== v[15:0])
        begin
            $error("max_body_length: expected %h, got %h", v[15:0], got[15:0]);
            mismatch_seen = 1'b1;
        end
        @(posedge clk);
    endtask

    function automatic void compare_field(
        input string       name,
        input logic [31:0] want,
        input logic [31:0] got
    );
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_seen = 1'b1;
        end
    endfunction

    always @(posedge clk)
    begin : word_check
        result_t want;
        if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (pending_words.size() == 0)
            begin
                $error("result word with nothing pending");
                mismatch_seen = 1'b1;
            end
            else
            begin
                want = pending_words.pop_front();
                compare_field("result_kind", 32'(want.result_kind),
                              32'(result_ch.result_kind));
                compare_field("body_byte", 32'(want.body_byte),
                              32'(result_ch.body_byte));
                compare_field("body_index", 32'(want.body_index),
                              32'(result_ch.body_index));
                compare_field("message_id", 32'(want.message_id),
                              32'(result_ch.message_id));
                compare_field("message_class", 32'(want.message_class),
                              32'(result_ch.message_class));
                compare_field("body_length", 32'(want.body_length),
                              32'(result_ch.body_length));
                compare_field("gps_week", 32'(want.gps_week),
                              32'(result_ch.gps_week));
                compare_field("week_milliseconds", want.week_milliseconds,
                              result_ch.week_milliseconds);
                compare_field("frame_status", 32'(want.frame_status),
                              32'(result_ch.frame_status));
            end
        end
    end

    initial
    begin : rx_pacing
        int   n;
        int   run_left;
        logic gappy;
        run_left = 0;
        gappy    = 1'b0;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            n = 0;
            if (run_left == 0)
            begin
                gappy    = ($urandom_range(0, 2) != 0);
                run_left = $urandom_range(16, 96);
            end
            run_left--;
            if (hold_off_req)
            begin
                n            = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            else if (gappy && $urandom_range(0, 3) == 0)
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
            if (n > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int         i;
        frame_row_t row;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= 8'h00;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_ROWS; i++)
            send_frame(directed_rows[i]);
        drain();

        write_reg(REG_CRC_POLY, 32'hFFFF_FFFF);
        write_reg(REG_MAX_LEN, 32'd0);
        random_traffic(90);
        drain();

        write_reg(REG_CRC_POLY, 32'd0);
        write_reg(REG_MAX_LEN, 32'h0000_FFFF);
        // hold the result side off while a long body streams in
        row = '{LEAD_CLEAN, ID_OBS, 16'd30, 16'd1, 32'd1, 1'b0, 1'b0, STATUS_GOOD};
        hold_off_req = 1'b1;
        send_frame(row);
        random_traffic(160);
        drain();

        write_reg(REG_CRC_POLY, $urandom);
        write_reg(REG_MAX_LEN, $urandom_range(0, 24));
        random_traffic(210);
        drain();

        write_reg(REG_CRC_POLY, CRC_POLY_RESET);
        write_reg(REG_MAX_LEN, {16'd0, MAX_LEN_RESET});
        random_traffic(220);
        drain();

        if (!mismatch_seen && pending_words.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
